/* design/cse_pkg.sv */
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and constants of the cosine similarity engine.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int DEF_MAX_LENGTH    = 4096;
    localparam int DEF_ELEMENT_WIDTH = 16;

    // Score and status field widths
    localparam int SCORE_W  = 16;
    localparam int STATUS_W = 2;

    // The cosine ratio is scaled by 2^FRAC_SHIFT before the root.
    // That gives 2^16 on the root, and so Q1.15 once the last bit is rounded off.
    localparam int FRAC_SHIFT = 32;
    localparam int QUOT_W     = FRAC_SHIFT + 1;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int ROOT_W     = FRAC_SHIFT + 2;
    localparam int SQRT_STEPS = FRAC_SHIFT / 2 + 1;
    localparam int Q_W        = FRAC_SHIFT / 2 + 1;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 16'h7FFF;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_LEN  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_ACC,
        S_LOAD,
        S_MUL,
        S_DSET,
        S_DIV,
        S_SQRT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic acc_en;
        logic load;
        logic mul_step;
        logic div_set;
        logic div_step;
        logic sqrt_step;
        logic emit;
    } cse_cmd_t;

    typedef struct packed {
        logic early;
        logic out_full;
    } cse_sts_t;

endpackage

/* design/cse_ctrl.sv */
// ----------------------------------------------------------------------------
// cse_ctrl
// Sequencer: accumulate, multiply, divide, root, emit; errors skip to emit.
// ----------------------------------------------------------------------------
module cse_ctrl #(
    parameter int SUM_W  = 45,
    parameter int ITER_W = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last,
    output logic              s_ready,
    input  cse_pkg::cse_sts_t sts,
    output cse_pkg::cse_cmd_t cmd
);
    import cse_pkg::*;

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_ACC;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_ACC: begin
                s_ready    = 1'b1;
                cmd.acc_en = s_valid;
                if (s_valid && s_last) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                cmd.load = 1'b1;
                cnt_next = '0;
                state_next = sts.early ? S_DONE : S_MUL;
            end
            S_MUL: begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == ITER_W'(SUM_W - 1)) begin
                    cnt_next   = '0;
                    state_next = S_DSET;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DSET: begin
                cmd.div_set = 1'b1;
                state_next  = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == ITER_W'(DIV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_SQRT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (cnt_reg == ITER_W'(SQRT_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = S_DONE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DONE: begin
                // hold until the result register is free
                if (!sts.out_full) begin
                    cmd.emit   = 1'b1;
                    state_next = S_ACC;
                end
            end
            default: state_next = S_ACC;
        endcase
    end

endmodule

/* design/cse_datapath.sv */
// ----------------------------------------------------------------------------
// cse_datapath
// Running sums, shift-add multipliers, restoring divider, integer root and
// result register.
// ----------------------------------------------------------------------------
module cse_datapath #(
    parameter int MAX_LENGTH    = 4096,
    parameter int ELEMENT_WIDTH = 16,
    parameter int CNT_W         = 13,
    parameter int SUM_W         = 45
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic signed [ELEMENT_WIDTH-1:0]       s_a_value,
    input  logic signed [ELEMENT_WIDTH-1:0]       s_b_value,
    input  cse_pkg::cse_cmd_t                     cmd,
    output cse_pkg::cse_sts_t                     sts,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [cse_pkg::SCORE_W-1:0]    m_score,
    output logic [cse_pkg::STATUS_W-1:0]          m_status
);
    import cse_pkg::*;

    localparam int PW = 2 * ELEMENT_WIDTH;
    localparam int NW = 2 * SUM_W;
    localparam int XW = NW + FRAC_SHIFT;

    // running sums
    logic signed [SUM_W-1:0] dot_reg;
    logic [SUM_W-1:0]        sqa_reg, sqb_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    exceeded_reg;

    logic signed [PW-1:0]    prod_ab, prod_aa, prod_bb;

    // end-of-vector work registers
    logic                    neg_reg;
    status_t                 code_reg;
    logic [NW-1:0]           mca_reg, mcp_reg, pn_reg, pp_reg;
    logic [SUM_W-1:0]        mba_reg, mbp_reg;
    logic [XW-1:0]           x_reg, d_reg;
    logic [QUOT_W-1:0]       quot_reg;
    logic [ROOT_W-1:0]       root_reg, bit_reg;

    logic                    zero_norm;
    logic [SUM_W-1:0]        mag;
    logic [ROOT_W-1:0]       trial;
    logic [Q_W:0]            q_sum;
    logic [Q_W-1:0]          q_mag;
    logic [SCORE_W-1:0]      score_next;

    assign prod_ab = s_a_value * s_b_value;
    assign prod_aa = s_a_value * s_a_value;
    assign prod_bb = s_b_value * s_b_value;

    assign zero_norm    = (sqa_reg == '0) || (sqb_reg == '0);
    assign sts.early    = exceeded_reg || zero_norm;
    assign sts.out_full = m_valid && !m_ready;

    assign mag   = dot_reg[SUM_W-1] ? $unsigned(-dot_reg) : $unsigned(dot_reg);
    assign trial = root_reg + bit_reg;

    // round to nearest: q = (root + 1) / 2
    assign q_sum = {1'b0, root_reg[Q_W-1:0]} + 1'b1;
    assign q_mag = q_sum[Q_W:1];

    always_comb begin
        if (code_reg != ST_OK) begin
            score_next = '0;
        end else if (neg_reg) begin
            score_next = SCORE_W'(-q_mag);
        end else if (q_mag > Q_W'(SCORE_MAX)) begin
            score_next = SCORE_MAX;
        end else begin
            score_next = q_mag[SCORE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg      <= '0;
            sqa_reg      <= '0;
            sqb_reg      <= '0;
            count_reg    <= '0;
            exceeded_reg <= 1'b0;
        end else if (cmd.load) begin
            dot_reg      <= '0;
            sqa_reg      <= '0;
            sqb_reg      <= '0;
            count_reg    <= '0;
            exceeded_reg <= 1'b0;
        end else if (cmd.acc_en) begin
            if (count_reg >= CNT_W'(MAX_LENGTH)) begin
                exceeded_reg <= 1'b1;
            end else begin
                dot_reg   <= dot_reg + SUM_W'(prod_ab);
                sqa_reg   <= sqa_reg + SUM_W'($unsigned(prod_aa));
                sqb_reg   <= sqb_reg + SUM_W'($unsigned(prod_bb));
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            neg_reg  <= dot_reg[SUM_W-1];
            code_reg <= exceeded_reg ? ST_LEN : (zero_norm ? ST_ZERO : ST_OK);
            mca_reg  <= NW'(sqa_reg);
            mba_reg  <= sqb_reg;
            mcp_reg  <= NW'(mag);
            mbp_reg  <= mag;
            pn_reg   <= '0;
            pp_reg   <= '0;
        end else if (cmd.mul_step) begin
            if (mba_reg[0]) begin
                pn_reg <= pn_reg + mca_reg;
            end
            if (mbp_reg[0]) begin
                pp_reg <= pp_reg + mcp_reg;
            end
            mca_reg <= mca_reg << 1;
            mcp_reg <= mcp_reg << 1;
            mba_reg <= mba_reg >> 1;
            mbp_reg <= mbp_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_set) begin
            x_reg    <= {pp_reg, FRAC_SHIFT'(0)};
            d_reg    <= {pn_reg, FRAC_SHIFT'(0)};
            quot_reg <= '0;
            root_reg <= '0;
            bit_reg  <= ROOT_W'(1) << FRAC_SHIFT;
        end else if (cmd.div_step) begin
            if (x_reg >= d_reg) begin
                x_reg    <= x_reg - d_reg;
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b1};
            end else begin
                quot_reg <= {quot_reg[QUOT_W-2:0], 1'b0};
            end
            d_reg <= d_reg >> 1;
        end else if (cmd.sqrt_step) begin
            if (ROOT_W'(quot_reg) >= trial) begin
                quot_reg <= quot_reg - trial[QUOT_W-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.emit) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_score  <= score_next;
            m_status <= code_reg;
        end
    end

endmodule

/* design/cosine_similarity_engine_unit.sv */
// ----------------------------------------------------------------------------
// cosine_similarity_engine_unit
// Streaming cosine similarity of two vectors, result in signed Q1.15.
// ----------------------------------------------------------------------------
//
//   channel  direction  ports                          word
//   s_       in         s_a_value, s_b_value, s_last   one element pair
//   m_       out        m_score, m_status              one result per vector
//
// Element pairs are taken at one per cycle while s_ready is high. After the
// pair marked last, s_ready stays low while the sequencer loads, runs the
// shift-add multiply, divide set-up, divide and root steps and waits in its
// final state; an error result goes straight from load to the final state.
// Reset is synchronous, active low, and clears sums, count and sequencer.
// A result waiting on m_ready does not stop the next vector streaming in;
// only the next result stalls in its final state until the word is taken.
//
module cosine_similarity_engine_unit #(
    parameter int MAX_LENGTH    = cse_pkg::DEF_MAX_LENGTH,
    parameter int ELEMENT_WIDTH = cse_pkg::DEF_ELEMENT_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [ELEMENT_WIDTH-1:0]     s_a_value,
    input  logic signed [ELEMENT_WIDTH-1:0]     s_b_value,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [cse_pkg::SCORE_W-1:0]  m_score,
    output logic [cse_pkg::STATUS_W-1:0]        m_status
);
    import cse_pkg::*;

    // count holds 0..MAX_LENGTH; sums hold the signed dot product with room
    localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
    localparam int SUM_W  = 2 * ELEMENT_WIDTH + CNT_W;
    localparam int ITER_W = $clog2(((SUM_W > DIV_STEPS) ? SUM_W : DIV_STEPS) + 1);

    cse_cmd_t cmd;
    cse_sts_t sts;

    cse_ctrl #(
        .SUM_W  (SUM_W),
        .ITER_W (ITER_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cse_datapath #(
        .MAX_LENGTH    (MAX_LENGTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH),
        .CNT_W         (CNT_W),
        .SUM_W         (SUM_W)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_a_value (s_a_value),
        .s_b_value (s_b_value),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_score   (m_score),
        .m_status  (m_status)
    );

    // drop input straight after the last word: the sums are busy
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("input taken while result is computed");

    // error results carry a zero score
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_ZERO || m_status == ST_LEN) |-> m_score == '0)
        else $error("non-zero score on error result");

    // no unused status code ever leaves
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == ST_OK || m_status == ST_ZERO || m_status == ST_LEN)
        else $error("illegal status code");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams element pairs through the cosine similarity engine and checks
// each score and status word against a cycle-free integer model of the
// sums, the Q1.15 rounding and the error flags.
// ----------------------------------------------------------------------------
module testbench;
    import cse_pkg::*;

    localparam int EW        = DEF_ELEMENT_WIDTH;
    localparam int MAXLEN    = DEF_MAX_LENGTH;
    localparam int LIMIT     = 2_000_000;
    localparam int DRAIN     = 200;

    typedef struct {
        logic signed [EW-1:0] a;
        logic signed [EW-1:0] b;
        logic                 last;
    } pair_t;

    typedef struct {
        logic signed [SCORE_W-1:0] score;
        status_t                   status;
    } verdict_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [EW-1:0] s_a_value = '0;
    logic signed [EW-1:0] s_b_value = '0;
    logic s_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [SCORE_W-1:0] m_score;
    logic [STATUS_W-1:0] m_status;

    pair_t    pair_q[$];
    verdict_t verdict_q[$];
    pair_t    cur_pair;
    int       cycles = 0;
    int       errors = 0;
    int       holdoff = 0;

    // Model state: exact running sums of the current vector
    longint   dot_acc = 0;
    longint   aa_acc = 0;
    longint   bb_acc = 0;
    int       pair_count = 0;
    bit       too_long = 1'b0;

    cosine_similarity_engine_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_value(s_a_value), .s_b_value(s_b_value), .s_last(s_last),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_score(m_score), .m_status(m_status)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Largest q with (2q-1)^2 * aa * bb <= 2^32 * dot^2, i.e. the rounded
    // magnitude; the sign of the dot product is applied afterwards.
    function automatic logic signed [SCORE_W-1:0] cosine_q15(longint dot, longint aa,
                                                             longint bb);
        logic [127:0] mag, rhs, norms, odd, lhs;
        int lo, hi, mid;
        mag   = (dot < 0) ? 128'(-dot) : 128'(dot);
        rhs   = (mag * mag) << 32;
        norms = 128'(aa) * 128'(bb);
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            odd = 128'(2 * mid - 1);
            lhs = odd * odd * norms;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        if (dot < 0) return SCORE_W'(-lo);
        return (lo > 32767) ? SCORE_MAX : SCORE_W'(lo);
    endfunction

    // Fold one accepted pair into the sums; on last, queue the verdict and clear
    task automatic absorb_pair(pair_t p);
        verdict_t v;
        longint a, b;
        a = p.a;
        b = p.b;
        if (pair_count >= MAXLEN) begin
            too_long = 1'b1;
        end else begin
            dot_acc += a * b;
            aa_acc  += a * a;
            bb_acc  += b * b;
            pair_count++;
        end
        if (p.last) begin
            v.score = '0;
            if (too_long) v.status = ST_LEN;
            else if (aa_acc == 0 || bb_acc == 0) v.status = ST_ZERO;
            else begin
                v.status = ST_OK;
                v.score  = cosine_q15(dot_acc, aa_acc, bb_acc);
            end
            verdict_q.push_back(v);
            dot_acc = 0;
            aa_acc = 0;
            bb_acc = 0;
            pair_count = 0;
            too_long = 1'b0;
        end
    endtask

    function automatic bit quiet_window();
        return cycles >= 3000 && cycles < 4500;
    endfunction

    // Driver: hold the word until taken, then advance or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) absorb_pair(cur_pair);
            if (!s_valid || s_ready) begin
                if (pair_q.size() > 0 && (quiet_window() || $urandom_range(99) >= 33)) begin
                    cur_pair = pair_q.pop_front();
                    s_a_value <= cur_pair.a;
                    s_b_value <= cur_pair.b;
                    s_last    <= cur_pair.last;
                    s_valid   <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the input backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (cycles == 6000) holdoff = 600;
            if (holdoff > 0) begin
                holdoff--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet_window() || ($urandom_range(99) >= 33);
            end
        end
    end

    // Monitor: compare each taken word with the oldest verdict
    always @(posedge aclk) begin
        verdict_t v;
        if (aresetn && m_valid && m_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected word score=%0d status=%0d", $time, m_score,
                         m_status);
                errors++;
            end else begin
                v = verdict_q.pop_front();
                if (m_score !== v.score) begin
                    $display("%0t: score expected %0d actual %0d", $time, v.score, m_score);
                    errors++;
                end
                if (m_status !== v.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, v.status,
                             m_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic put_pair(int a, int b, bit last);
        pair_t p;
        p.a = EW'(a);
        p.b = EW'(b);
        p.last = last;
        pair_q.push_back(p);
    endtask

    // One random vector; shape picks plain noise, parallel, anti-parallel,
    // extreme values, a zero vector on one side or small values on the b side
    task automatic put_vector(int len);
        int shape, a, b;
        shape = $urandom_range(5);
        for (int i = 0; i < len; i++) begin
            a = $signed(16'($urandom()));
            b = $signed(16'($urandom()));
            case (shape)
                1: b = a;
                2: b = (a == -32768) ? 32767 : -a;
                3: begin
                    a = $urandom_range(1) ? -32768 : 32767;
                    b = $urandom_range(1) ? -32768 : 32767;
                end
                4: a = 0;
                5: b = $signed(16'($urandom_range(15))) - 8;
                default: ;
            endcase
            put_pair(a, b, i == len - 1);
        end
    endtask

    initial begin
        int fed;
        // Directed: extremes, exact +1 and -1, zero norms, orthogonal
        put_pair(32767, 32767, 1);
        put_pair(-32768, -32768, 1);
        put_pair(-32768, 32767, 1);
        put_pair(1, -1, 1);
        put_pair(0, 5, 1);
        put_pair(7, 0, 1);
        put_pair(0, 0, 1);
        put_pair(3, 4, 0);
        put_pair(4, -3, 1);
        put_pair(0, 0, 0);
        put_pair(1, 2, 0);
        put_pair(2, 1, 1);
        put_pair(-1, 32767, 0);
        put_pair(32767, -1, 1);
        // Random vectors, mostly short
        fed = pair_q.size();
        while (fed < 1050) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(80, 20) : $urandom_range(12, 1);
            put_vector(len);
            fed += len;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        do @(posedge aclk);
        while (pair_q.size() != 0 || s_valid || verdict_q.size() != 0);
        repeat (DRAIN) @(posedge aclk);

        if (errors == 0 && verdict_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
